>>> src/dlbd_pkg.sv
// shared types and codes for the definite-length block deframer
package dlbd_pkg;

    localparam int unsigned MAX_LEN_DIGITS = 9;
    localparam int unsigned LEN_W          = 30;

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 30'd4096;

    // result event codes
    localparam logic [2:0] EV_HEADER  = 3'd0;
    localparam logic [2:0] EV_DELIVER = 3'd1;
    localparam logic [2:0] EV_DRAIN   = 3'd2;
    localparam logic [2:0] EV_END     = 3'd3;
    localparam logic [2:0] EV_ERROR   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_BAD_COUNT = 2'd2;
    localparam logic [1:0] ST_TOO_BIG   = 2'd3;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [7:0]       payload_byte;
        logic             last_payload;
        logic [1:0]       status;
        logic [LEN_W-1:0] block_length;
    } t_result;

endpackage

>>> src/definite_length_block_deframer_unit.sv
// definite-length block deframer: '#', digit count, length digits, payload, trailer
//
// The unit takes one received word per cycle on the input channel and gives
// exactly one result word for each, in the cycle after the word is accepted unless
// the result side stalls. A block is '#', a count digit '1'..'9', that many
// ASCII length digits, the payload, and one trailer word that is swallowed
// whatever its value. Header words give event 0, payload words give event 1
// (delivered, with the byte and a last flag) or event 2 (drained, when the
// length exceeds max_payload as it stood on the last length digit), and the
// trailer gives event 3 with the parsed length and status ok or too big. A bad
// start word or bad count gives event 4 at once and the parser waits for '#'
// again. The length value stops at the first non-digit among the length digits.
// Sustained rate is one word per cycle unless o_stall holds the input: the parse
// state is updated combinationally and registered per accepted word, and a two-entry
// output stage (result register plus skid register) lets a new word enter while a
// result waits; o_stall comes straight from the skid register. max_payload is
// written through i_max_payload_we / i_max_payload and resets to 4096.
module definite_length_block_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_max_payload_we,
    input  logic [29:0] i_max_payload,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_payload,
    output logic [1:0]  o_status,
    output logic [29:0] o_block_length
);

    // parser phases
    localparam logic [2:0] PH_HASH    = 3'd0;
    localparam logic [2:0] PH_COUNT   = 3'd1;
    localparam logic [2:0] PH_DIGITS  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_TRAILER = 3'd4;

    localparam int unsigned LW = dlbd_pkg::LEN_W;

    // parse state
    logic [2:0]    r_phase,        n_phase;
    logic [3:0]    r_digits_left,  n_digits_left;
    logic [LW-1:0] r_length_accum, n_length_accum;
    logic          r_length_frozen, n_length_frozen;
    logic [LW-1:0] r_bytes_left,   n_bytes_left;
    logic          r_oversize,     n_oversize;
    logic [LW-1:0] r_max_payload;

    // output stage
    logic                r_out_valid;
    logic                r_skid_valid;
    dlbd_pkg::t_result   r_out;
    dlbd_pkg::t_result   r_skid;
    dlbd_pkg::t_result   n_res;

    logic          accept_in;
    logic          is_digit;
    logic [3:0]    digit_val;
    logic          count_ok;
    logic [LW-1:0] accum_step;
    logic [LW-1:0] accum_upd;
    logic [3:0]    digits_dec;
    logic [LW-1:0] bytes_dec;

    assign accept_in = i_valid && !r_skid_valid;
    assign o_stall   = r_skid_valid;

    assign is_digit  = (i_rx_byte >= dlbd_pkg::CHAR_ZERO) && (i_rx_byte <= dlbd_pkg::CHAR_NINE);
    // ascii digits sit at 0x30..0x39, so the low nibble is the value
    assign digit_val = i_rx_byte[3:0];
    assign count_ok  = is_digit && (digit_val != 4'd0)
                       && (digit_val <= 4'(dlbd_pkg::MAX_LEN_DIGITS));

    // accum * 10 + digit as two shifts and two adds, wrapped to the length width
    assign accum_step = {r_length_accum[LW-4:0], 3'b000} + {r_length_accum[LW-2:0], 1'b0}
                        + LW'(digit_val);
    assign accum_upd  = (!r_length_frozen && is_digit) ? accum_step : r_length_accum;
    assign digits_dec = r_digits_left - 4'd1;
    assign bytes_dec  = r_bytes_left - LW'(1);

    // next parse state and the result for the word on the input
    always_comb begin
        n_phase         = r_phase;
        n_digits_left   = r_digits_left;
        n_length_accum  = r_length_accum;
        n_length_frozen = r_length_frozen;
        n_bytes_left    = r_bytes_left;
        n_oversize      = r_oversize;

        n_res.event_res    = dlbd_pkg::EV_HEADER;
        n_res.payload_byte = 8'd0;
        n_res.last_payload = 1'b0;
        n_res.status       = dlbd_pkg::ST_OK;
        n_res.block_length = '0;

        case (r_phase)
            PH_COUNT: begin
                if (!count_ok) begin
                    n_phase         = PH_HASH;
                    n_res.event_res = dlbd_pkg::EV_ERROR;
                    n_res.status    = dlbd_pkg::ST_BAD_COUNT;
                end else begin
                    n_digits_left   = digit_val;
                    n_length_accum  = '0;
                    n_length_frozen = 1'b0;
                    n_phase         = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                n_length_accum  = accum_upd;
                n_length_frozen = r_length_frozen || !is_digit;
                n_digits_left   = digits_dec;
                if (digits_dec == 4'd0) begin
                    // length known: load the payload counter and size check
                    n_bytes_left = accum_upd;
                    n_oversize   = accum_upd > r_max_payload;
                    n_phase      = (accum_upd == '0) ? PH_TRAILER : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_bytes_left = bytes_dec;
                if (bytes_dec == '0) begin
                    n_phase = PH_TRAILER;
                end
                if (r_oversize) begin
                    n_res.event_res = dlbd_pkg::EV_DRAIN;
                end else begin
                    n_res.event_res    = dlbd_pkg::EV_DELIVER;
                    n_res.payload_byte = i_rx_byte;
                    n_res.last_payload = (r_bytes_left == LW'(1));
                end
            end
            PH_TRAILER: begin
                n_phase            = PH_HASH;
                n_res.event_res    = dlbd_pkg::EV_END;
                n_res.status       = r_oversize ? dlbd_pkg::ST_TOO_BIG : dlbd_pkg::ST_OK;
                n_res.block_length = r_length_accum;
            end
            default: begin
                // waiting for the start byte
                if (i_rx_byte == dlbd_pkg::CHAR_HASH) begin
                    n_phase = PH_COUNT;
                end else begin
                    n_phase         = PH_HASH;
                    n_res.event_res = dlbd_pkg::EV_ERROR;
                    n_res.status    = dlbd_pkg::ST_BAD_START;
                end
            end
        endcase
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HASH;
            r_digits_left   <= 4'd0;
            r_length_accum  <= '0;
            r_length_frozen <= 1'b0;
            r_bytes_left    <= '0;
            r_oversize      <= 1'b0;
        end else if (accept_in) begin
            r_phase         <= n_phase;
            r_digits_left   <= n_digits_left;
            r_length_accum  <= n_length_accum;
            r_length_frozen <= n_length_frozen;
            r_bytes_left    <= n_bytes_left;
            r_oversize      <= n_oversize;
        end
    end

    // size limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= dlbd_pkg::MAX_PAYLOAD_RST;
        end else if (i_max_payload_we) begin
            r_max_payload <= i_max_payload;
        end
    end

    // result register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept_in;
                if (accept_in) begin
                    r_out <= n_res;
                end
            end
        end else if (accept_in) begin
            r_skid       <= n_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_res    = r_out.event_res;
    assign o_payload_byte = r_out.payload_byte;
    assign o_last_payload = r_out.last_payload;
    assign o_status       = r_out.status;
    assign o_block_length = r_out.block_length;

`ifndef SYNTH
    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without result word");

    // length is reported only on block end
    a_len_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_res != dlbd_pkg::EV_END)) |-> (o_block_length == '0))
        else $error("block length outside block end");

    // last flag only on a delivered payload word
    a_last_on_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_payload) |-> (o_event_res == dlbd_pkg::EV_DELIVER))
        else $error("last flag on non-delivered word");

    // payload phase always has words left to count
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_bytes_left != '0))
        else $error("payload phase with empty counter");
`endif

endmodule

>>> bench/deframer_checker.sv
// result checker for the definite-length block deframer: predicts each result word and compares
module deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [29:0] i_cfg_max_payload,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_event_res,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_payload,
    input  logic [1:0]  i_status,
    input  logic [29:0] i_block_length,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [2:0] {
        WAIT_HASH,
        GET_COUNT,
        GET_DIGITS,
        IN_PAYLOAD,
        GET_TRAILER
    } t_deframe_phase;

    t_deframe_phase             parse_phase;
    logic [3:0]                 digits_left;
    logic [dlbd_pkg::LEN_W-1:0] length_accum;
    logic                       length_frozen;
    logic [dlbd_pkg::LEN_W-1:0] bytes_left;
    logic                       oversize;
    logic [dlbd_pkg::LEN_W-1:0] max_payload_copy;

    dlbd_pkg::t_result expected_results[$];

    // advances the parse state by one received word and gives its result word
    function automatic dlbd_pkg::t_result predict_deframe(input logic [7:0] b);
        dlbd_pkg::t_result r;
        logic              is_digit;
        r = '0;
        is_digit = (b >= dlbd_pkg::CHAR_ZERO) && (b <= dlbd_pkg::CHAR_NINE);
        case (parse_phase)
            GET_COUNT: begin
                if (!is_digit || b == dlbd_pkg::CHAR_ZERO
                        || int'(b - dlbd_pkg::CHAR_ZERO) > dlbd_pkg::MAX_LEN_DIGITS) begin
                    parse_phase = WAIT_HASH;
                    r.event_res = dlbd_pkg::EV_ERROR;
                    r.status    = dlbd_pkg::ST_BAD_COUNT;
                end else begin
                    digits_left   = 4'(b - dlbd_pkg::CHAR_ZERO);
                    length_accum  = '0;
                    length_frozen = 1'b0;
                    parse_phase   = GET_DIGITS;
                    r.event_res   = dlbd_pkg::EV_HEADER;
                end
            end
            GET_DIGITS: begin
                // value stops growing at the first non-digit
                if (!length_frozen && is_digit)
                    length_accum = length_accum * 30'd10 + 30'(b - dlbd_pkg::CHAR_ZERO);
                else
                    length_frozen = 1'b1;
                digits_left = digits_left - 4'd1;
                if (digits_left == 4'd0) begin
                    bytes_left  = length_accum;
                    oversize    = length_accum > max_payload_copy;
                    parse_phase = (length_accum == '0) ? GET_TRAILER : IN_PAYLOAD;
                end
                r.event_res = dlbd_pkg::EV_HEADER;
            end
            IN_PAYLOAD: begin
                r.last_payload = (bytes_left == 30'd1);
                bytes_left = bytes_left - 30'd1;
                if (bytes_left == '0)
                    parse_phase = GET_TRAILER;
                if (oversize) begin
                    r.event_res    = dlbd_pkg::EV_DRAIN;
                    r.last_payload = 1'b0;
                end else begin
                    r.event_res    = dlbd_pkg::EV_DELIVER;
                    r.payload_byte = b;
                end
            end
            GET_TRAILER: begin
                parse_phase    = WAIT_HASH;
                r.event_res    = dlbd_pkg::EV_END;
                r.status       = oversize ? dlbd_pkg::ST_TOO_BIG : dlbd_pkg::ST_OK;
                r.block_length = length_accum;
            end
            default: begin
                parse_phase = WAIT_HASH;
                if (b == dlbd_pkg::CHAR_HASH) begin
                    parse_phase = GET_COUNT;
                    r.event_res = dlbd_pkg::EV_HEADER;
                end else begin
                    r.event_res = dlbd_pkg::EV_ERROR;
                    r.status    = dlbd_pkg::ST_BAD_START;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        dlbd_pkg::t_result want;
        if (!i_rst_n) begin
            parse_phase      = WAIT_HASH;
            digits_left      = '0;
            length_accum     = '0;
            length_frozen    = 1'b0;
            bytes_left       = '0;
            oversize         = 1'b0;
            max_payload_copy = dlbd_pkg::MAX_PAYLOAD_RST;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display({"%0t: result word with none expected, ",
                              "expected none actual %0d/%0d/%0d/%0d/%0d"},
                             $time, i_event_res, i_payload_byte, i_last_payload, i_status,
                             i_block_length);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_res", want.event_res, i_event_res);
                    check_field("payload_byte", want.payload_byte, i_payload_byte);
                    check_field("last_payload", want.last_payload, i_last_payload);
                    check_field("status", want.status, i_status);
                    check_field("block_length", want.block_length, i_block_length);
                end
            end
            if (i_cfg_we)
                max_payload_copy = i_cfg_max_payload;
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_deframe(i_rx_byte));
        end
        o_pending = expected_results.size();
    end

endmodule

>>> bench/tb_definite_length_block_deframer_unit.sv
// testbench top for the definite-length block deframer: stimulus, idling and verdict
module tb_definite_length_block_deframer_unit;

    // generous bound: ~750 words, each slowed a few times over by idling, plus hold-offs
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_WORDS_PER_PHASE = 175;
    localparam int LONG_HOLD_OFF = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_max_payload_we;
    logic [29:0] i_max_payload;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_event_res;
    logic [7:0]  o_payload_byte;
    logic        o_last_payload;
    logic [1:0]  o_status;
    logic [29:0] o_block_length;

    int fail_count;
    int pending_results;
    int cycle_count;
    int words_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_left;

    definite_length_block_deframer_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_max_payload_we (i_max_payload_we),
        .i_max_payload    (i_max_payload),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_res      (o_event_res),
        .o_payload_byte   (o_payload_byte),
        .o_last_payload   (o_last_payload),
        .o_status         (o_status),
        .o_block_length   (o_block_length)
    );

    deframer_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_max_payload_we),
        .i_cfg_max_payload (i_max_payload),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_rx_byte         (i_rx_byte),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_event_res       (o_event_res),
        .i_payload_byte    (o_payload_byte),
        .i_last_payload    (o_last_payload),
        .i_status          (o_status),
        .i_block_length    (o_block_length),
        .o_fail_count      (fail_count),
        .o_pending         (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout: a hung handshake ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: a long hold-off takes priority over the random stall rate
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                i_stall <= 1'b1;
                hold_off_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic bit is_digit(input logic [7:0] b);
        return (b >= dlbd_pkg::CHAR_ZERO) && (b <= dlbd_pkg::CHAR_NINE);
    endfunction

    function automatic logic [7:0] pick_non_digit();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (is_digit(b));
        return b;
    endfunction

    // number of length digits needed to spell len
    function automatic int digits_for(input int unsigned len);
        int n;
        n = 1;
        while (len >= 10) begin
            len = len / 10;
            n++;
        end
        return n;
    endfunction

    // offers one word, with random idle cycles first; entered and left at a falling edge
    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // stops offering and waits until every result word has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0)
            @(negedge i_clk);
        // spare settling time after the last result word
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_max_payload(input logic [29:0] value);
        i_max_payload_we <= 1'b1;
        i_max_payload    <= value;
        @(negedge i_clk);
        i_max_payload_we <= 1'b0;
    endtask

    // whole block: '#', count, zero-padded length digits (one optionally spoiled by a
    // non-digit), as many payload words as the digits actually spell, then the trailer
    task automatic send_block(input int n_digits, input int unsigned len, input int spoil_at);
        logic [7:0]  digit_chars [dlbd_pkg::MAX_LEN_DIGITS];
        int unsigned rest;
        int unsigned body_len;
        bit          frozen;
        rest     = len;
        body_len = 0;
        frozen   = 1'b0;
        for (int k = n_digits - 1; k >= 0; k--) begin
            digit_chars[k] = dlbd_pkg::CHAR_ZERO + 8'(rest % 10);
            rest = rest / 10;
        end
        if (spoil_at >= 0)
            digit_chars[spoil_at] = pick_non_digit();
        send_word(dlbd_pkg::CHAR_HASH);
        send_word(dlbd_pkg::CHAR_ZERO + 8'(n_digits));
        for (int k = 0; k < n_digits; k++) begin
            if (!frozen && is_digit(digit_chars[k]))
                body_len = body_len * 10 + int'(digit_chars[k] - dlbd_pkg::CHAR_ZERO);
            else
                frozen = 1'b1;
            send_word(digit_chars[k]);
        end
        repeat (body_len) send_word(8'($urandom_range(255)));
        send_word(8'($urandom_range(255)));
    endtask

    // mostly well-formed blocks with random content, some noise and broken headers
    task automatic send_random_words(input int target);
        int          start;
        int          roll;
        int unsigned len;
        int          n;
        int          spoil_at;
        logic [7:0]  b;
        start = words_sent;
        while (words_sent - start < target) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
                len      = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(24);
                n        = $urandom_range(dlbd_pkg::MAX_LEN_DIGITS, digits_for(len));
                spoil_at = ($urandom_range(6) == 0) ? $urandom_range(n - 1) : -1;
                send_block(n, len, spoil_at);
            end else if (roll < 90) begin
                // stray words while waiting for the start
                repeat ($urandom_range(3, 1)) begin
                    do b = 8'($urandom_range(255)); while (b == dlbd_pkg::CHAR_HASH);
                    send_word(b);
                end
            end else begin
                // start followed by a count that is not '1'..'9'
                do b = 8'($urandom_range(255));
                while (b > dlbd_pkg::CHAR_ZERO && b <= dlbd_pkg::CHAR_NINE);
                send_word(dlbd_pkg::CHAR_HASH);
                send_word(b);
            end
        end
    endtask

    initial begin
        logic [29:0] small_max;
        i_rst_n          = 1'b0;
        i_max_payload_we = 1'b0;
        i_max_payload    = '0;
        i_valid          = 1'b0;
        i_rx_byte        = '0;
        i_stall          = 1'b0;
        words_sent       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_left    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at the reset max_payload, no idling
        send_word(8'h00);                          // bad start byte, low extreme
        send_word(8'hFF);                          // bad start byte, high extreme
        send_word(dlbd_pkg::CHAR_HASH);
        send_word(dlbd_pkg::CHAR_ZERO);            // count of zero is bad
        send_word(dlbd_pkg::CHAR_HASH);
        send_word(dlbd_pkg::CHAR_NINE + 8'd1);     // just past '9'
        send_block(dlbd_pkg::MAX_LEN_DIGITS, 0, -1); // widest count, zero length
        send_word(dlbd_pkg::CHAR_HASH);
        send_word(dlbd_pkg::CHAR_ZERO + 8'd1);
        send_word(dlbd_pkg::CHAR_ZERO + 8'd2);
        send_word(8'h00);                          // payload byte extremes
        send_word(8'hFF);
        send_word(8'h5A);                          // trailer
        send_block(3, 15, 2);                      // non-digit freezes the value at "01"
        send_block(1, 5, 0);                       // leading non-digit gives length 0

        // max_payload changed after the length is decided: block still delivered
        send_word(dlbd_pkg::CHAR_HASH);
        send_word(dlbd_pkg::CHAR_ZERO + 8'd2);
        send_word(dlbd_pkg::CHAR_ZERO + 8'd1);
        send_word(dlbd_pkg::CHAR_ZERO);
        drain_results();
        write_max_payload('0);
        repeat (10) send_word(8'($urandom_range(255)));
        send_word(8'($urandom_range(255)));

        // every nonzero length drained; long receiver hold-off fills the unit
        drain_results();
        hold_off_left = LONG_HOLD_OFF;
        send_random_words(RANDOM_WORDS_PER_PHASE);

        // register all ones, sender idling
        drain_results();
        write_max_payload('1);
        send_idle_pct = 65;
        send_random_words(RANDOM_WORDS_PER_PHASE);

        // small max, receiver stalling; boundary lengths first
        drain_results();
        small_max = 30'($urandom_range(40, 8));
        write_max_payload(small_max);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        send_block(digits_for(small_max), small_max, -1);
        send_block(digits_for(small_max + 1), small_max + 1, -1);
        send_random_words(RANDOM_WORDS_PER_PHASE);

        // random max, both sides idling lightly
        drain_results();
        write_max_payload(30'($urandom_range(64)));
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        send_random_words(RANDOM_WORDS_PER_PHASE);

        drain_results();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
